>>> hdl/wbps_pkg.sv
// package for the wildcard byte pattern scanner
// holds the operation codes, item and configuration types and queue sizing
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SCAN   = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] REG_BASE_ADDRESS   = 2'd1;
	localparam logic [1:0] REG_CAPTURE_LIMIT  = 2'd2;

	typedef struct packed {
		op_t        op;
		logic [4:0] token_index;
		logic [7:0] token_value;
		logic       token_care;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic [5:0]  pattern_length;
		logic [31:0] base_address;
		logic [15:0] report_limit;
	} cfg_t;

endpackage

`default_nettype wire

>>> hdl/wbps_front.sv
// front end: accepts input transactions, decodes the operation and queues them
// depends on wbps_pkg
`timescale 1ns / 1ps
`default_nettype none

module wbps_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [23:0]         s_tdata,  // token_index[4:0], token_value, token_care, text_byte
	input  wire  [1:0]          s_tuser,  // op
	output logic                q_valid,
	input  wire                 q_ready,
	output wbps_pkg::item_t     q_item
);
	import wbps_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               known_op;
	logic               push;
	logic               pop;
	item_t              in_item;

	always_comb begin
		in_item.op          = op_t'(s_tuser);
		in_item.token_index = s_tdata[4:0];
		in_item.token_value = s_tdata[12:5];
		in_item.token_care  = s_tdata[13];
		in_item.text_byte   = s_tdata[21:14];
		case (s_tuser)
			OP_LOAD, OP_SCAN, OP_FINISH: known_op = 1'b1;
			default:                     known_op = 1'b0;
		endcase
	end

	assign s_tready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	// unused op codes are dropped here and never reach the engine
	assign push     = s_tvalid && s_tready && known_op;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/wbps_back.sv
// back end: token store, shift-and match vector, counters and output register
// depends on wbps_pkg
`timescale 1ns / 1ps
`default_nettype none

module wbps_back #(
	parameter int PATTERN_MAX = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wbps_pkg::cfg_t      cfg,
	input  wire                 q_valid,
	output logic                q_ready,
	input  wbps_pkg::item_t     q_item,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [63:0]         m_tdata,  // match_address, hit_total
	output logic [0:0]          m_tuser   // kind
);
	import wbps_pkg::*;

	logic [7:0]             tok_byte_q [PATTERN_MAX];
	logic                   tok_care_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] vec_q;
	logic [31:0]            off_q;
	logic [31:0]            total_q;

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [31:0]            out_addr_q;
	logic [31:0]            out_count_q;

	logic [PATTERN_MAX-1:0] mask;
	logic [PATTERN_MAX-1:0] vec_next;
	logic                   hit;
	logic                   advance;
	logic [31:0]            total_inc;
	logic [31:0]            start_addr;
	logic                   capture;
	logic                   produce;

	always_comb begin
		hit = 1'b0;
		for (int pos = 0; pos < PATTERN_MAX; pos++) begin
			mask[pos] = (pos < int'(cfg.pattern_length)) &&
				(!tok_care_q[pos] || (tok_byte_q[pos] == q_item.text_byte));
			vec_next[pos] = ((pos == 0) ? 1'b1 : vec_q[(pos == 0) ? 0 : pos - 1]) & mask[pos];
			// the top of the pattern decides a full match
			if (pos == int'(cfg.pattern_length) - 1) begin
				hit = vec_next[pos];
			end
		end
	end

	assign total_inc  = (total_q != '1) ? total_q + 32'd1 : total_q;
	assign capture    = (total_q < {16'd0, cfg.report_limit});
	assign start_addr = cfg.base_address + off_q + 32'd1 - {26'd0, cfg.pattern_length};

	assign q_ready = !out_valid_q || m_tready;
	assign advance = q_valid && q_ready;
	// finish always reports, a scan only on a captured match
	assign produce = (q_item.op == OP_FINISH) ||
		((q_item.op == OP_SCAN) && hit && capture);

	always_ff @(posedge clk) begin
		if (advance && (q_item.op == OP_LOAD)) begin
			for (int pos = 0; pos < PATTERN_MAX; pos++) begin
				if (int'(q_item.token_index) == pos) begin
					tok_byte_q[pos] <= q_item.token_value;
					tok_care_q[pos] <= q_item.token_care;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q       <= '0;
			off_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && produce) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				case (q_item.op)
					OP_SCAN: begin
						vec_q <= vec_next;
						off_q <= off_q + 32'd1;
						if (hit) begin
							total_q <= total_inc;
						end
					end
					OP_FINISH: begin
						vec_q   <= '0;
						off_q   <= '0;
						total_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (q_item.op)
				OP_SCAN: begin
					out_kind_q  <= KIND_MATCH;
					out_addr_q  <= start_addr;
					out_count_q <= total_inc;
				end
				OP_FINISH: begin
					out_kind_q  <= KIND_SUMMARY;
					out_addr_q  <= '0;
					out_count_q <= total_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_addr_q};
	assign m_tuser  = out_kind_q;

endmodule

`default_nettype wire

>>> hdl/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner, top level.
// Input stream s_*: s_tuser carries the operation (load token, scan byte, finish),
// s_tdata the token fields and the text byte. Output stream m_*: m_tuser is the
// kind (match report or finish summary), m_tdata the start address and the count.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 pattern length,
// 1 base address, 2 capture limit); write only while no transactions are in flight.
// Throughput: one input transaction per cycle while m_tready keeps the output moving,
// set by the shift-and update of the partial match vector in the back end.
// A result is registered in the queue and then in the back end's output register
// after its input is accepted; it waits in the queue while the engine is stalled.
// A four-entry queue sits between the decode front end and the match engine; when
// m_tready is low the engine holds its result register, the queue fills and
// s_tready falls once it is full.
// Reset clears the match vector, byte offset, match count, configuration and
// queue; pattern tokens must be loaded before they are scanned.
// depends on wbps_pkg, wbps_front, wbps_back
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner_top #(
	parameter int PATTERN_MAX = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_addr,
	input  wire  [31:0] cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,  // token_index[4:0], token_value, token_care, text_byte
	input  wire  [1:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,  // match_address[31:0], hit_total[63:32]
	output logic [0:0]  m_tuser   // kind
);
	import wbps_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata[5:0];
				REG_BASE_ADDRESS:   cfg_q.base_address   <= cfg_wdata;
				REG_CAPTURE_LIMIT:  cfg_q.report_limit   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	wbps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	wbps_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the wildcard byte pattern scanner: directed cases, backpressure and
// random pattern/text traffic, every result compared against an in-bench predictor
// depends on wbps_pkg and wildcard_byte_pattern_scanner_top
`timescale 1ns / 1ps

module tb_top;
	import wbps_pkg::*;

	localparam int PMAX        = 32;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_WAIT  = 10;      // margin after the last result for inputs still in the queue and the engine
	localparam logic [1:0] OP_NONE = 2'd3; // unused operation code, block ignores it

	// one input transaction, field by field
	typedef struct packed {
		logic [1:0] op;
		logic [4:0] idx;
		logic [7:0] value;
		logic       care;
		logic [7:0] text;
	} scan_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [31:0] count;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // token_index[4:0], token_value, token_care, text_byte
	logic [1:0]  s_tuser = '0;  // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;       // match_address[31:0], hit_total[63:32]
	logic [0:0]  m_tuser;       // kind

	// predictor state
	logic [7:0]  tok_byte [PMAX];
	logic        tok_care [PMAX];
	logic [31:0] partial;
	logic [31:0] offset;
	logic [31:0] total;
	logic [5:0]  plen;
	logic [31:0] base_addr;
	logic [15:0] cap;

	report_t expected_reports [$];
	report_t got_rep, want_rep;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int rx_hold = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int reports_checked = 0;
	int match_reports = 0;
	int summaries = 0;
	int mismatches = 0;

	wildcard_byte_pattern_scanner_top #(
		.PATTERN_MAX(PMAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results still expected", $time,
				expected_reports.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when rx_hold is set
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_rep = {m_tuser[0], m_tdata[31:0], m_tdata[63:32]};
			if (expected_reports.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: kind %0d addr %h count %0d", $time,
					got_rep.kind, got_rep.addr, got_rep.count);
			end else begin
				want_rep = expected_reports.pop_front();
				reports_checked++;
				if (want_rep.kind == KIND_MATCH)
					match_reports++;
				else
					summaries++;
				if (got_rep.kind !== want_rep.kind) begin
					mismatches++;
					$display("%0t kind mismatch: expected %0d actual %0d", $time,
						want_rep.kind, got_rep.kind);
				end
				if (got_rep.addr !== want_rep.addr) begin
					mismatches++;
					$display("%0t match_address mismatch: expected %h actual %h", $time,
						want_rep.addr, got_rep.addr);
				end
				if (got_rep.count !== want_rep.count) begin
					mismatches++;
					$display("%0t hit total mismatch: expected %0d actual %0d", $time,
						want_rep.count, got_rep.count);
				end
			end
		end
	end

	// predictor for one accepted transaction: stores tokens, shift-and update on scans; queues the result it causes
	task automatic predict_scanner(input scan_item_t it);
		logic [31:0] mask;
		logic [31:0] off;
		logic [31:0] prev_total;
		logic        hit;
		report_t     rep;
		case (it.op)
			OP_LOAD: begin
				tok_byte[it.idx] = it.value;
				tok_care[it.idx] = it.care;
			end
			OP_SCAN: begin
				mask = '0;
				for (int p = 0; p < PMAX; p++)
					if (p < plen && (!tok_care[p] || tok_byte[p] == it.text))
						mask[p] = 1'b1;
				partial = {partial[30:0], 1'b1} & mask;
				hit = (plen >= 1 && plen <= PMAX) ? partial[plen - 1] : 1'b0;
				off = offset;
				offset = offset + 32'd1;
				if (hit) begin
					prev_total = total;
					if (total != 32'hFFFF_FFFF)
						total = total + 32'd1;
					if (prev_total < {16'd0, cap}) begin
						rep.kind = KIND_MATCH;
						rep.addr = base_addr + off - ({26'd0, plen} - 32'd1);
						rep.count = total;
						expected_reports.insert(expected_reports.size(), rep);
					end
				end
			end
			OP_FINISH: begin
				rep.kind = KIND_SUMMARY;
				rep.addr = 32'd0;
				rep.count = total;
				expected_reports.insert(expected_reports.size(), rep);
				partial = '0;
				offset = '0;
				total = '0;
			end
			default: ;
		endcase
	endtask

	function automatic scan_item_t load_item(input int idx, input logic [7:0] value,
		input logic care);
		scan_item_t it;
		it = scan_item_t'(24'($urandom));
		it.op = OP_LOAD;
		it.idx = idx[4:0];
		it.value = value;
		it.care = care;
		return it;
	endfunction

	function automatic scan_item_t scan_item(input logic [7:0] text);
		scan_item_t it;
		it = scan_item_t'(24'($urandom));
		it.op = OP_SCAN;
		it.text = text;
		return it;
	endfunction

	function automatic scan_item_t ctl_item(input logic [1:0] op);
		scan_item_t it;
		it = scan_item_t'(24'($urandom));
		it.op = op;
		return it;
	endfunction

	// half the time a byte that some pattern token wants, so exact tokens hit often
	function automatic logic [7:0] pick_text_byte(input int span);
		if (span > 0 && $urandom_range(1))
			return tok_byte[$urandom_range(span - 1)];
		return 8'($urandom);
	endfunction

	task automatic send_item(input scan_item_t it);
		int gap;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b00, it.text, it.care, it.value, it.idx};
		do @(posedge clk); while (!s_tready);
		predict_scanner(it);
		if (it.op != OP_NONE)
			items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_PATTERN_LENGTH: plen = value[5:0];
			REG_BASE_ADDRESS:   base_addr = value;
			REG_CAPTURE_LIMIT:  cap = value[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	// loads and unmatched scans give no result, so let the pipeline drain too
	task automatic wait_quiet;
		wait_results();
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic test_overlap_and_capture;
		logic [7:0] text_seq [10];
		text_seq = '{8'h00, 8'h11, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
		write_reg(REG_PATTERN_LENGTH, 32'd3);
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFE);
		write_reg(REG_CAPTURE_LIMIT, 32'd2);
		send_item(load_item(0, 8'h00, 1'b1));
		send_item(load_item(1, 8'h5A, 1'b0));
		send_item(load_item(2, 8'hFF, 1'b1));
		send_item(load_item(31, 8'hFF, 1'b1));
		// overlapping starts, only the first two report, addresses wrap past zero
		foreach (text_seq[i])
			send_item(scan_item(text_seq[i]));
		send_item(ctl_item(OP_FINISH));
		send_item(ctl_item(OP_NONE));
		send_item(ctl_item(OP_FINISH));
	endtask

	task automatic test_length_edges;
		// text shorter than the pattern
		send_item(scan_item(8'h00));
		send_item(scan_item(8'h11));
		send_item(ctl_item(OP_FINISH));
		wait_quiet();
		write_reg(REG_PATTERN_LENGTH, 32'd0);
		write_reg(REG_BASE_ADDRESS, 32'd0);
		send_item(scan_item(8'hFF));
		wait_quiet();
		// length change mid-scan, matches counted but none reported
		write_reg(REG_PATTERN_LENGTH, 32'd1);
		write_reg(REG_CAPTURE_LIMIT, 32'd0);
		send_item(scan_item(8'h00));
		send_item(scan_item(8'h00));
		send_item(ctl_item(OP_FINISH));
	endtask

	task automatic test_backpressure;
		wait_quiet();
		send_idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_PATTERN_LENGTH, 32'd1);
		write_reg(REG_CAPTURE_LIMIT, 32'h0000_FFFF);
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
		send_item(load_item(0, 8'h00, 1'b0));
		// every byte matches while the receiver holds off, so the input must stall
		rx_hold = 200;
		repeat (24) send_item(scan_item(8'($urandom)));
		wait_results();
		repeat (12) send_item(scan_item(8'($urandom)));
		send_item(ctl_item(OP_FINISH));
	endtask

	task automatic run_scan_round(input int force_len);
		int r;
		int span;
		int nbytes;
		int n;
		logic [5:0] len;
		wait_quiet();
		r = $urandom_range(99);
		if (force_len >= 0)
			len = force_len[5:0];
		else if (r < 5)
			len = 6'd0;
		else if (r < 10)
			len = 6'd32;
		else if (r < 14)
			len = 6'($urandom_range(33, 63));
		else if (r < 22)
			len = 6'($urandom_range(9, 31));
		else
			len = 6'($urandom_range(1, 8));
		write_reg(REG_PATTERN_LENGTH, {26'd0, len});
		if ($urandom_range(99) < 60) begin
			r = $urandom_range(99);
			if (r < 40)
				write_reg(REG_BASE_ADDRESS, $urandom);
			else if (r < 60)
				write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF0 + $urandom_range(15));
			else
				write_reg(REG_BASE_ADDRESS, $urandom_range(255) << 12);
		end
		if ($urandom_range(99) < 50) begin
			r = $urandom_range(99);
			if (r < 15)
				write_reg(REG_CAPTURE_LIMIT, 32'd0);
			else if (r < 35)
				write_reg(REG_CAPTURE_LIMIT, 32'h0000_FFFF);
			else
				write_reg(REG_CAPTURE_LIMIT, $urandom_range(1, 12));
		end
		// every token the scan can read gets written first
		span = (len > PMAX) ? PMAX : len;
		for (int p = 0; p < span; p++)
			send_item(load_item(p, 8'($urandom), ($urandom_range(99) < 75)));
		nbytes = $urandom_range(20, 60);
		n = 0;
		while (n < nbytes) begin
			r = $urandom_range(99);
			if (r < 3) begin
				send_item(ctl_item(OP_NONE));
			end else if (r < 6) begin
				send_item(load_item($urandom_range(31), 8'($urandom), 1'($urandom)));
			end else if (r < 8) begin
				send_item(ctl_item(OP_FINISH));
			end else if (r < 35 && span > 0 && len <= PMAX) begin
				// a full pattern instance, wildcards filled at random
				for (int p = 0; p < span; p++)
					send_item(scan_item(tok_care[p] ? tok_byte[p] : 8'($urandom)));
				n += span;
			end else begin
				send_item(scan_item(pick_text_byte(span)));
				n++;
			end
		end
		// sometimes leave the scan open so the next settings apply mid-scan
		if ($urandom_range(99) < 85)
			send_item(ctl_item(OP_FINISH));
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall,
		input int count, input int first_len);
		int target;
		wait_quiet();
		send_idle_pct = idle_pct;
		stall_pct = stall;
		target = items_sent + count;
		run_scan_round(first_len);
		while (items_sent < target)
			run_scan_round(-1);
	endtask

	initial begin
		partial = '0;
		offset = '0;
		total = '0;
		plen = '0;
		base_addr = '0;
		cap = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_overlap_and_capture();
		test_length_edges();
		test_backpressure();
		test_random_traffic(0, 0, 400, 63);
		test_random_traffic(65, 0, 400, 32);
		test_random_traffic(0, 65, 400, 40);
		test_random_traffic(20, 20, 400, 0);
		wait_quiet();
		$display("covered %0d transactions: overlapping and wildcard matches, capture limits,",
			items_sent);
		$display("length extremes, backpressure; %0d match reports and %0d summaries checked",
			match_reports, summaries);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
